// File: hw/rtl/golay24_pkg.sv
`timescale 1ns / 1ps

package golay24_pkg;

    typedef logic [11:0] t_half;
    typedef logic [3:0]  t_count;

    // Row r of the symmetric generator part B; bit c holds column c.
    localparam logic [11:0][11:0] B_ROWS = {
        12'b0111_1111_1111,
        12'b1100_0111_0110,
        12'b1000_1110_1101,
        12'b1001_1101_1010,
        12'b1011_1011_0100,
        12'b1111_0110_1000,
        12'b1110_1101_0001,
        12'b1101_1010_0011,
        12'b1011_0100_0111,
        12'b1110_1000_1110,
        12'b1101_0001_1101,
        12'b1010_0011_1011
    };

    localparam t_count MAX_WEIGHT = 4'd3;
    localparam t_count ROW_WEIGHT = 4'd2;

    function automatic t_count pop12(input t_half v);
        t_count n;
        n = '0;
        for (int k = 0; k < 12; k++) begin
            n = n + t_count'(v[k]);
        end
        return n;
    endfunction

    function automatic t_half times_b(input t_half v);
        t_half acc;
        acc = '0;
        for (int r = 0; r < 12; r++) begin
            if (v[r]) begin
                acc = acc ^ B_ROWS[r];
            end
        end
        return acc;
    endfunction

    // One-hot mask of the lowest row r with weight(v ^ B_r) <= 2, zero if none.
    function automatic t_half lowest_row(input t_half v);
        t_half hits;
        for (int r = 0; r < 12; r++) begin
            hits[r] = (pop12(v ^ B_ROWS[r]) <= ROW_WEIGHT);
        end
        return hits & (~hits + 12'd1);
    endfunction

    function automatic t_half select_row(input t_half onehot);
        t_half acc;
        acc = '0;
        for (int r = 0; r < 12; r++) begin
            if (onehot[r]) begin
                acc = acc | B_ROWS[r];
            end
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/golay_24_12_decoder.sv
// Extended Golay (24,12) decoder, corrects up to three bit errors per word.
// Input channel: i_valid / o_ready with i_received_word; bits 0 to 11 are
// parity and bits 12 to 23 are the message.
// Output channel: o_valid / i_ready with o_decoded_message and
// o_uncorrectable; an uncorrectable word gives a zero message.
// A beat is taken on each edge where valid and ready are both high.
// It takes one beat per cycle unless stalled and holds no state between words.
// It is a four-register pipeline: input register, syndrome, second syndrome
// with first row search, and output register.
// When the receiver holds i_ready low with a result waiting, every stage
// freezes and o_ready falls; nothing is lost or repeated.
// o_ready is high whenever the output register is empty or being taken.
// Synchronous active-low reset clears all valid bits; payload registers
// are not reset.
`timescale 1ns / 1ps

module golay_24_12_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_received_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_decoded_message,
    output logic        o_uncorrectable
);

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [23:0]         r_word;
    golay24_pkg::t_half  r_high2, r_s;
    golay24_pkg::t_half  r_high3, r_s2, r_row1;
    logic                r_ok1;
    golay24_pkg::t_half  r_msg;
    logic                r_bad;

    golay24_pkg::t_half  n_s, n_s2, n_row1, n_row2, n_msg;
    logic                n_ok1, n_bad;
    logic                w_adv;

    assign w_adv   = !r_v4 || i_ready;
    assign o_ready = w_adv;

    always_comb begin
        n_s    = r_word[11:0] ^ golay24_pkg::times_b(r_word[23:12]);
        n_s2   = golay24_pkg::times_b(r_s);
        n_ok1  = (golay24_pkg::pop12(r_s) <= golay24_pkg::MAX_WEIGHT);
        n_row1 = golay24_pkg::lowest_row(r_s);
        n_row2 = golay24_pkg::lowest_row(r_s2);
        n_bad  = 1'b0;
        if (r_ok1) begin
            n_msg = r_high3;
        end else if (r_row1 != '0) begin
            n_msg = r_high3 ^ r_row1;
        end else if (golay24_pkg::pop12(r_s2) <= golay24_pkg::MAX_WEIGHT) begin
            n_msg = r_high3 ^ r_s2;
        end else if (n_row2 != '0) begin
            n_msg = r_high3 ^ r_s2 ^ golay24_pkg::select_row(n_row2);
        end else begin
            n_msg = '0;
            n_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_word  <= i_received_word;
            r_high2 <= r_word[23:12];
            r_s     <= n_s;
            r_high3 <= r_high2;
            r_s2    <= n_s2;
            r_ok1   <= n_ok1;
            r_row1  <= n_row1;
            r_msg   <= n_msg;
            r_bad   <= n_bad;
        end
    end

    assign o_valid           = r_v4;
    assign o_decoded_message = r_msg;
    assign o_uncorrectable   = r_bad;

endmodule

// File: hw/rtl/golay24_checker.sv
`timescale 1ns / 1ps

module golay24_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_decoded_message,
    input logic        o_uncorrectable
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_decoded_message)
            && $stable(o_uncorrectable))
        else $error("Stalled output beat changed.");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_uncorrectable |-> o_decoded_message == 12'd0)
        else $error("Uncorrectable beat carries a nonzero message.");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("Input stalled while the pipeline can move.");

endmodule

bind golay_24_12_decoder golay24_checker u_golay24_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_decoded_message (o_decoded_message),
    .o_uncorrectable   (o_uncorrectable)
);
